// ===== rtl/core/altl_pkg.sv =====
// Shared types and constants for the arc-length table locator.
package altl_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 4096;

  localparam int unsigned OPCODE_W    = 1;
  localparam int unsigned ENTRY_IDX_W = 12;
  localparam int unsigned DIST_W      = 24;
  localparam int unsigned PARAM_W     = 22;
  localparam int unsigned CANT_W      = 12;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned SPAN_W      = 10;
  localparam int unsigned U_W         = 13;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned QW          = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned ENTRY_W    = DIST_W + PARAM_W + CANT_W;
  localparam int unsigned DIST_LSB   = PARAM_W + CANT_W;
  localparam int unsigned PARAM_LSB  = CANT_W;

  localparam int unsigned QBITS      = QW + 1;
  localparam int unsigned QCNT_W     = $clog2(QBITS);
  localparam int unsigned REM_W      = DIST_W + 1;
  localparam int unsigned MUL_A_W    = QW + 2;
  localparam int unsigned MUL_B_W    = PARAM_W + 1;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned SCALED_W   = PROD_W - QW;

  localparam logic [OPCODE_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_LOCATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_COUNT  = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_HI_RD,
    ST_HI_GOT,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_C,
    ST_FINISH
  } altl_state_e;

endpackage

// ===== rtl/core/arc_length_table_locate_core.sv =====
// Arc-length table locator core: table load, binary search, serial divide, interpolation.
// Write items (opcode 0) store one table entry; writes to an index beyond the table are dropped.
// A query (opcode 1) holds the block: the binary search walks the table through the one read
// port of the entry RAM, and the interpolation fraction comes from a 17-step restoring divider
// followed by two passes through one shared 18x23 multiplier. The divider is skipped when the
// upper entry of the bracketing pair has no greater distance than the lower one. Degenerate
// tracks finish without a search, as does a track whose last entry's distance is zero. The
// input side stalls while a query is in progress; a finished result sits in the output register
// and the next item is taken while it waits. Table entries read before they are written are
// undefined; configuration must be written only while the block is idle, which is not enforced.
module arc_length_table_locate_core #(
  parameter int unsigned TABLE_DEPTH = altl_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [altl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [altl_pkg::CFG_DATA_W-1:0]      cfg_data_i,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [altl_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [altl_pkg::ENTRY_IDX_W-1:0]     entry_index_i,
  input  logic [altl_pkg::DIST_W-1:0]          arc_pos_i,
  input  logic [altl_pkg::PARAM_W-1:0]         param_pos_i,
  input  logic signed [altl_pkg::CANT_W-1:0]   cant_value_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 located_o,
  output logic [altl_pkg::SPAN_W-1:0]          span_index_o,
  output logic [altl_pkg::U_W-1:0]             local_u_o,
  output logic signed [altl_pkg::CANT_W-1:0]   cant_angle_o
);

  import altl_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned NW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ULIM = 1 << FRAC_BITS;

  altl_state_e state_q, state_d;

  logic [COUNT_W-1:0] entry_count_q;
  logic [SPAN_W-1:0]  span_count_q;
  logic               out_valid_q;

  logic [DIST_W-1:0]  s_q;
  logic [AW-1:0]      lo_q, hi_q;
  logic [DIST_W-1:0]  d_lo_q;
  logic [PARAM_W-1:0] p_lo_q, p_hi_q;
  logic [CANT_W-1:0]  c_lo_q, c_hi_q;
  logic [DIST_W-1:0]  den_q;
  logic [REM_W-1:0]   rem_q;
  logic [QBITS-1:0]   frac_q;
  logic [QCNT_W-1:0]  div_cnt_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [PARAM_W-1:0] g_q;
  logic               degen_q;

  logic               located_q;
  logic [SPAN_W-1:0]  span_out_q;
  logic [U_W-1:0]     u_out_q;
  logic [CANT_W-1:0]  cant_out_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [DIST_W-1:0]  rd_dist;
  logic [PARAM_W-1:0] rd_param;
  logic [CANT_W-1:0]  rd_cant;

  logic               in_xfer, is_write, is_query, idx_ok;
  logic [NW-1:0]      n_w;
  logic               query_degen;
  logic               len_zero;
  logic [AW:0]        mid_sum;
  logic [AW-1:0]      mid;
  logic               search_more;
  logic               dist_le;
  logic               den_pos;
  logic [DIST_W-1:0]  den_w, num_raw, num_w;
  logic               div_ge;
  logic [REM_W-1:0]   rem_sub;
  logic               out_free;
  logic               load_out;
  logic signed [MUL_B_W-1:0] dp_w, mul_b;
  logic signed [CANT_W:0]    dc_w;
  logic signed [PROD_W-1:0]  prod_w;
  logic signed [SCALED_W-1:0] g_full;
  logic [SPAN_W-1:0]  span_raw, span_max, span_sel;
  logic [PARAM_W:0]   u_full;
  logic [U_W-1:0]     u_sel;
  logic [CANT_W:0]    cant_full;

  assign rd_dist  = ram_rdata[ENTRY_W-1:DIST_LSB];
  assign rd_param = ram_rdata[DIST_LSB-1:PARAM_LSB];
  assign rd_cant  = ram_rdata[CANT_W-1:0];

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign is_write = opcode_i == OP_WRITE;
  assign is_query = opcode_i == OP_LOCATE;
  assign idx_ok   = 32'(entry_index_i) < 32'(TABLE_DEPTH);

  assign n_w = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(entry_count_q);
  assign query_degen = (span_count_q == '0) || (n_w < NW'(2));
  assign len_zero    = rd_dist == '0;

  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = mid_sum[AW:1];
  assign search_more = (hi_q - lo_q) > AW'(1);
  assign dist_le     = rd_dist <= s_q;

  assign den_pos = rd_dist > d_lo_q;
  assign den_w   = rd_dist - d_lo_q;
  assign num_raw = (s_q > d_lo_q) ? (s_q - d_lo_q) : '0;
  assign num_w   = (num_raw > den_w) ? den_w : num_raw;

  assign div_ge  = rem_q >= {1'b0, den_q};
  assign rem_sub = div_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  assign out_free = !out_valid_q || !out_stall_i;

  assign dp_w   = $signed({1'b0, p_hi_q}) - $signed({1'b0, p_lo_q});
  assign dc_w   = $signed({c_hi_q[CANT_W-1], c_hi_q}) - $signed({c_lo_q[CANT_W-1], c_lo_q});
  assign mul_b  = (state_q == ST_MUL_C) ? MUL_B_W'(dc_w) : dp_w;
  assign prod_w = $signed({1'b0, frac_q}) * mul_b;

  assign g_full = $signed(SCALED_W'(p_lo_q)) + prod_q[PROD_W-1:QW];

  assign span_raw = g_q[PARAM_W-1:FRAC_BITS];
  assign span_max = span_count_q - SPAN_W'(1);
  assign span_sel = (span_raw > span_max) ? span_max : span_raw;
  assign u_full   = {1'b0, g_q} - {1'b0, span_sel, {FRAC_BITS{1'b0}}};
  assign u_sel    = (u_full > (PARAM_W + 1)'(ULIM)) ? U_W'(ULIM) : u_full[U_W-1:0];
  assign cant_full = {c_lo_q[CANT_W-1], c_lo_q} + prod_q[QW+CANT_W:QW];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_query) begin
          state_d = query_degen ? ST_FINISH : ST_LEN_RD;
        end
      end
      ST_LEN_RD:   state_d = ST_LEN_CHK;
      ST_LEN_CHK:  state_d = len_zero ? ST_FINISH : ST_SRCH_RD;
      ST_SRCH_RD:  state_d = search_more ? ST_SRCH_CMP : ST_HI_RD;
      ST_SRCH_CMP: state_d = ST_SRCH_RD;
      ST_HI_RD:    state_d = ST_HI_GOT;
      ST_HI_GOT:   state_d = den_pos ? ST_DIV : ST_MUL_P;
      ST_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = ST_MUL_P;
        end
      end
      ST_MUL_P:    state_d = ST_MUL_C;
      ST_MUL_C:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_raddr  = hi_q;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_we     = in_xfer && is_write && idx_ok;
      end
      ST_SRCH_RD: ram_raddr = search_more ? mid : lo_q;
      ST_FINISH:  load_out  = out_free;
      default: begin
        ram_raddr = hi_q;
      end
    endcase
  end

  assign ram_waddr = AW'(entry_index_i);
  assign ram_wdata = {arc_pos_i, param_pos_i, cant_value_i};

  altl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      span_count_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ENTRY_COUNT: entry_count_q <= cfg_data_i;
          REG_SPAN_COUNT:  span_count_q  <= cfg_data_i[SPAN_W-1:0];
          default: begin
            entry_count_q <= entry_count_q;
          end
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        s_q     <= arc_pos_i;
        lo_q    <= '0;
        hi_q    <= AW'(n_w - NW'(1));
        degen_q <= query_degen;
      end
      ST_LEN_CHK: begin
        degen_q <= len_zero;
        if (s_q > rd_dist) begin
          s_q <= rd_dist;
        end
      end
      ST_SRCH_CMP: begin
        if (dist_le) begin
          lo_q <= mid;
        end else begin
          hi_q <= mid;
        end
      end
      ST_HI_RD: begin
        d_lo_q <= rd_dist;
        p_lo_q <= rd_param;
        c_lo_q <= rd_cant;
      end
      ST_HI_GOT: begin
        p_hi_q    <= rd_param;
        c_hi_q    <= rd_cant;
        den_q     <= den_w;
        rem_q     <= {1'b0, num_w};
        frac_q    <= '0;
        div_cnt_q <= QCNT_W'(QBITS - 1);
      end
      ST_DIV: begin
        frac_q    <= {frac_q[QBITS-2:0], div_ge};
        rem_q     <= {rem_sub[REM_W-2:0], 1'b0};
        div_cnt_q <= div_cnt_q - QCNT_W'(1);
      end
      ST_MUL_P: begin
        prod_q <= prod_w;
      end
      ST_MUL_C: begin
        g_q    <= g_full[PARAM_W-1:0];
        prod_q <= prod_w;
      end
      default: begin
        s_q <= s_q;
      end
    endcase
    if (load_out) begin
      located_q  <= !degen_q;
      span_out_q <= degen_q ? '0 : span_sel;
      u_out_q    <= degen_q ? '0 : u_sel;
      cant_out_q <= degen_q ? '0 : cant_full[CANT_W-1:0];
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign located_o    = located_q;
  assign span_index_o = span_out_q;
  assign local_u_o    = u_out_q;
  assign cant_angle_o = $signed(cant_out_q);

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !located_o |-> span_index_o == '0 && local_u_o == '0 && cant_angle_o == '0)
    else $error("degenerate result carries nonzero fields");

  a_u_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && located_o |-> local_u_o <= U_W'(ULIM))
    else $error("local u above one");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH_CMP |-> lo_q < hi_q)
    else $error("search bracket collapsed");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> den_q != '0 && rem_q < {den_q, 1'b0})
    else $error("divider remainder out of range");

endmodule

// ===== rtl/core/altl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module altl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/arc_length_table_locate_core_tb.sv =====
// Self-checking testbench for the arc-length table locator core with a built-in predictor.
`timescale 1ns / 1ps

module arc_length_table_locate_core_tb;
  import altl_pkg::*;

  localparam int unsigned TABLE_DEPTH   = DEF_TABLE_DEPTH;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned RANDOM_ITEMS  = 200;
  localparam int unsigned FINAL_FILL    = 256;
  localparam int unsigned DIST_MAX      = 24'hFF_FFFF;
  localparam int unsigned PARAM_MAX     = 22'h3F_FFFF;
  localparam int          CANT_LIMIT    = 1721;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic                     located;
    logic [SPAN_W-1:0]        span_idx;
    logic [U_W-1:0]           local_u;
    logic signed [CANT_W-1:0] cant;
  } loc_result_t;

  localparam loc_result_t NO_LOC = '0;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_data;
    logic [OPCODE_W-1:0]      op;
    logic [ENTRY_IDX_W-1:0]   entry;
    logic [DIST_W-1:0]        arc;
    logic [PARAM_W-1:0]       param;
    logic signed [CANT_W-1:0] cant;
    bit                       typed;
    loc_result_t              want;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [CFG_IDX_W-1:0]           cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]          cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [OPCODE_W-1:0]            opcode_i = OP_WRITE;
  logic [ENTRY_IDX_W-1:0]         entry_index_i = '0;
  logic [DIST_W-1:0]              arc_pos_i = '0;
  logic [PARAM_W-1:0]             param_pos_i = '0;
  logic signed [CANT_W-1:0]       cant_value_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           located_o;
  logic [SPAN_W-1:0]              span_index_o;
  logic [U_W-1:0]                 local_u_o;
  logic signed [CANT_W-1:0]       cant_angle_o;

  logic [DIST_W-1:0]        track_dist  [TABLE_DEPTH];
  logic [PARAM_W-1:0]       track_param [TABLE_DEPTH];
  logic signed [CANT_W-1:0] track_cant  [TABLE_DEPTH];
  logic [COUNT_W-1:0]       track_entries = '0;
  logic [SPAN_W-1:0]        track_spans = '0;

  loc_result_t  expected_locs[$];
  stim_row_t    directed[$];
  int unsigned  mismatch_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;
  int unsigned  hold_cycles = 0;
  bit           steady_mode = 1'b0;

  arc_length_table_locate_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .entry_index_i(entry_index_i),
    .arc_pos_i    (arc_pos_i),
    .param_pos_i  (param_pos_i),
    .cant_value_i (cant_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .located_o    (located_o),
    .span_index_o (span_index_o),
    .local_u_o    (local_u_o),
    .cant_angle_o (cant_angle_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic loc_result_t locate_point(input logic [DIST_W-1:0] query);
    loc_result_t res;
    int unsigned used, lo, hi, mid;
    longint      s, d_lo, d_hi, num, den, frac, g, span, u, cant;
    res = NO_LOC;
    used = (track_entries > TABLE_DEPTH) ? TABLE_DEPTH : track_entries;
    if (track_spans == 0 || used < 2) return res;
    if (track_dist[used-1] == 0) return res;
    s = query;
    if (s > track_dist[used-1]) s = track_dist[used-1];
    lo = 0;
    hi = used - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (track_dist[mid] <= s) lo = mid;
      else hi = mid;
    end
    d_lo = track_dist[lo];
    d_hi = track_dist[hi];
    frac = 0;
    if (d_hi > d_lo) begin
      den = d_hi - d_lo;
      num = (s > d_lo) ? s - d_lo : 0;
      if (num > den) num = den;
      frac = (num << QW) / den;
    end
    g = longint'(track_param[lo])
      + ((frac * (longint'(track_param[hi]) - longint'(track_param[lo]))) >>> QW);
    span = g >>> FRAC_BITS;
    if (span > longint'(track_spans) - 1) span = longint'(track_spans) - 1;
    if (span < 0) span = 0;
    u = g - (span << FRAC_BITS);
    if (u < 0) u = 0;
    if (u > (longint'(1) << FRAC_BITS)) u = longint'(1) << FRAC_BITS;
    cant = longint'(track_cant[lo])
         + ((frac * (longint'(track_cant[hi]) - longint'(track_cant[lo]))) >>> QW);
    res.located  = 1'b1;
    res.span_idx = span[SPAN_W-1:0];
    res.local_u  = u[U_W-1:0];
    res.cant     = cant[CANT_W-1:0];
    return res;
  endfunction

  function automatic loc_result_t loc_at(input int unsigned span, input int unsigned u,
                                         input int cant);
    loc_result_t res;
    res.located  = 1'b1;
    res.span_idx = span[SPAN_W-1:0];
    res.local_u  = u[U_W-1:0];
    res.cant     = cant[CANT_W-1:0];
    return res;
  endfunction

  function automatic stim_row_t item_row(input logic [OPCODE_W-1:0] op,
                                         input logic [ENTRY_IDX_W-1:0] entry,
                                         input logic [DIST_W-1:0] arc,
                                         input logic [PARAM_W-1:0] param,
                                         input logic signed [CANT_W-1:0] cant,
                                         input bit typed, input loc_result_t want);
    stim_row_t row;
    row.kind     = ROW_ITEM;
    row.reg_idx  = REG_ENTRY_COUNT;
    row.reg_data = '0;
    row.op       = op;
    row.entry    = entry;
    row.arc      = arc;
    row.param    = param;
    row.cant     = cant;
    row.typed    = typed;
    row.want     = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = item_row(OP_WRITE, '0, '0, '0, '0, PREDICTED, NO_LOC);
    row.kind     = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic void add_row(input stim_row_t row);
    directed = {directed, row};
  endfunction

  function automatic logic signed [CANT_W-1:0] rand_cant();
    int c;
    c = int'($urandom_range(0, 2 * CANT_LIMIT)) - CANT_LIMIT;
    return c[CANT_W-1:0];
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (steady_mode) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DIST_W-1:0] pick_query(input int unsigned used);
    int unsigned top, pos;
    top = (used == 0) ? DIST_MAX : track_dist[used-1];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIST_W'(DIST_MAX);
      2, 3: return DIST_W'($urandom_range(0, DIST_MAX));
      4, 5: return (used == 0) ? '0 : track_dist[$urandom_range(0, used - 1)];
      default: begin
        pos = $urandom_range(0, top + top / 8);
        return (pos > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(pos);
      end
    endcase
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    loc_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{located_o, span_index_o, local_u_o, cant_angle_o};
      if (expected_locs.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_locs.pop_front();
        if ($isunknown(got)) begin
          $display("%0t: result expected %h got %h", $time, want, got);
          mismatch_count++;
        end else begin
          check_field("located", want.located, got.located);
          check_field("span_index", want.span_idx, got.span_idx);
          check_field("local_u", want.local_u, got.local_u);
          check_field("cant_angle", want.cant, got.cant);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    int unsigned gap;
    if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      gap = idle_gap();
      if (gap != 0) begin
        hold_cycles = gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [OPCODE_W-1:0] op,
                           input logic [ENTRY_IDX_W-1:0] entry,
                           input logic [DIST_W-1:0] arc,
                           input logic [PARAM_W-1:0] param,
                           input logic signed [CANT_W-1:0] cant,
                           input bit typed, input loc_result_t want);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    entry_index_i <= entry;
    arc_pos_i     <= arc;
    param_pos_i   <= param;
    cant_value_i  <= cant;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (op == OP_LOCATE) begin
      expected_locs = {expected_locs, (typed ? want : locate_point(arc))};
    end else begin
      track_dist[entry]  = arc;
      track_param[entry] = param;
      track_cant[entry]  = cant;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (expected_locs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ENTRY_COUNT: track_entries = data[COUNT_W-1:0];
      REG_SPAN_COUNT:  track_spans   = data[SPAN_W-1:0];
      default: ;
    endcase
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: cycle limit reached", $time);
    $display("arc_length_table_locate_core test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned n, k, m, pick, max_step, dist_acc, param_acc;
    bit          sorted;

    add_row(item_row(OP_LOCATE, '0, 24'h00_0000, '0, '0, TYPED, NO_LOC));
    add_row(item_row(OP_LOCATE, '1, 24'hFF_FFFF, '1, '0, TYPED, NO_LOC));
    add_row(reg_row(REG_SPAN_COUNT, 13'd5));
    add_row(item_row(OP_LOCATE, '0, 24'h12_3456, '0, '0, TYPED, NO_LOC));
    add_row(item_row(OP_WRITE, 12'd0, 24'h00_0000, 22'h00_0000, -12'sd1721,
                     PREDICTED, NO_LOC));
    add_row(reg_row(REG_ENTRY_COUNT, 13'd1));
    add_row(item_row(OP_LOCATE, '0, 24'h00_0000, '0, '0, TYPED, NO_LOC));
    add_row(item_row(OP_WRITE, 12'd1, 24'h00_0000, 22'h3F_FFFF, 12'sd1721,
                     PREDICTED, NO_LOC));
    add_row(reg_row(REG_ENTRY_COUNT, 13'd2));
    add_row(item_row(OP_LOCATE, '0, 24'h80_0000, '0, '0, TYPED, NO_LOC));
    add_row(item_row(OP_WRITE, 12'd1, 24'hFF_FFFF, 22'h3F_FFFF, 12'sd1721,
                     PREDICTED, NO_LOC));
    add_row(item_row(OP_LOCATE, '0, 24'h00_0000, '0, '0, TYPED,
                     loc_at(0, 0, -1721)));
    add_row(item_row(OP_LOCATE, '0, 24'hFF_FFFF, '0, '0, TYPED,
                     loc_at(4, 4096, 1721)));
    add_row(item_row(OP_LOCATE, '1, 24'h7F_FFFF, '1, '1, PREDICTED, NO_LOC));
    add_row(reg_row(REG_SPARE_A, 13'h1FFF));
    add_row(reg_row(REG_SPARE_B, 13'h0000));
    add_row(item_row(OP_LOCATE, '0, 24'h40_0000, '0, '0, PREDICTED, NO_LOC));
    add_row(reg_row(REG_SPAN_COUNT, 13'h1FFF));
    add_row(item_row(OP_LOCATE, '0, 24'hFF_FFFF, '0, '0, TYPED,
                     loc_at(1022, 4096, 1721)));
    add_row(reg_row(REG_SPAN_COUNT, 13'd0));
    add_row(item_row(OP_LOCATE, '0, 24'h00_0100, '0, '0, TYPED, NO_LOC));
    add_row(reg_row(REG_SPAN_COUNT, 13'd3));
    add_row(item_row(OP_WRITE, 12'd2, 24'd3000, 22'h00_2800, 12'sd900,
                     PREDICTED, NO_LOC));
    add_row(item_row(OP_WRITE, 12'd0, 24'd1000, 22'h00_3000, -12'sd500,
                     PREDICTED, NO_LOC));
    add_row(item_row(OP_WRITE, 12'd1, 24'd200, 22'h00_1000, 12'sd1200,
                     PREDICTED, NO_LOC));
    add_row(reg_row(REG_ENTRY_COUNT, 13'd3));
    add_row(item_row(OP_LOCATE, '0, 24'd2500, '0, '0, PREDICTED, NO_LOC));
    add_row(item_row(OP_LOCATE, '0, 24'd100, '0, '0, PREDICTED, NO_LOC));
    add_row(item_row(OP_LOCATE, '0, 24'd5000, '0, '0, PREDICTED, NO_LOC));
    add_row(item_row(OP_LOCATE, '0, 24'd1000, '0, '0, PREDICTED, NO_LOC));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_REG) begin
        write_reg(directed[r].reg_idx, directed[r].reg_data);
      end else begin
        send_item(directed[r].op, directed[r].entry, directed[r].arc, directed[r].param,
                  directed[r].cant, directed[r].typed, directed[r].want);
      end
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 2) n = pick;
      else if (pick < 16) n = $urandom_range(2, 32);
      else n = $urandom_range(33, 200);

      sorted    = ($urandom_range(0, 4) != 0);
      max_step  = ($urandom_range(0, 2) == 0 && n != 0) ? DIST_MAX / n : 2000;
      dist_acc  = $urandom_range(0, 1) ? 0 : $urandom_range(0, 500);
      param_acc = $urandom_range(0, 8191);
      for (k = 0; k < n; k++) begin
        if (sorted) begin
          send_item(OP_WRITE, ENTRY_IDX_W'(k), DIST_W'(dist_acc), PARAM_W'(param_acc),
                    rand_cant(), PREDICTED, NO_LOC);
        end else begin
          send_item(OP_WRITE, ENTRY_IDX_W'(k), DIST_W'($urandom_range(0, DIST_MAX)),
                    PARAM_W'($urandom_range(0, PARAM_MAX)), rand_cant(), PREDICTED, NO_LOC);
        end
        dist_acc  = dist_acc + $urandom_range(0, max_step);
        param_acc = param_acc + $urandom_range(0, 6000);
        if (dist_acc > DIST_MAX) dist_acc = DIST_MAX;
        if (param_acc > PARAM_MAX) param_acc = PARAM_MAX;
      end

      write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(n));
      case ($urandom_range(0, 9))
        0: write_reg(REG_SPAN_COUNT, '0);
        1: write_reg(REG_SPAN_COUNT, CFG_DATA_W'($urandom_range(0, 13'h1FFF)));
        2: write_reg(REG_SPAN_COUNT, 13'd1023);
        default: write_reg(REG_SPAN_COUNT, CFG_DATA_W'($urandom_range(1, 64)));
      endcase

      m = $urandom_range(8, 30);
      repeat (m) begin
        if ($urandom_range(0, 4) == 0) begin
          k = ($urandom_range(0, 1) && n != 0) ? $urandom_range(0, n - 1)
                                                : $urandom_range(0, TABLE_DEPTH - 1);
          send_item(OP_WRITE, ENTRY_IDX_W'(k), DIST_W'($urandom_range(0, DIST_MAX)),
                    PARAM_W'($urandom_range(0, PARAM_MAX)), rand_cant(), PREDICTED, NO_LOC);
        end else begin
          send_item(OP_LOCATE, ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                    pick_query(n), PARAM_W'($urandom_range(0, PARAM_MAX)), rand_cant(),
                    PREDICTED, NO_LOC);
        end
      end
    end

    steady_mode = 1'b0;
    dist_acc = 0;
    for (k = 0; k < FINAL_FILL; k++) begin
      send_item(OP_WRITE, ENTRY_IDX_W'(k), DIST_W'(dist_acc),
                PARAM_W'(k * 16384 + $urandom_range(0, 16383)), rand_cant(),
                PREDICTED, NO_LOC);
      dist_acc = dist_acc + $urandom_range(1, 4000);
    end
    write_reg(REG_SPAN_COUNT, 13'd1023);
    write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(FINAL_FILL));
    repeat (30) begin
      send_item(OP_LOCATE, ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                pick_query(FINAL_FILL), PARAM_W'($urandom_range(0, PARAM_MAX)), rand_cant(),
                PREDICTED, NO_LOC);
    end
    m = $urandom_range(2, FINAL_FILL);
    write_reg(REG_SPAN_COUNT, CFG_DATA_W'($urandom_range(1, 1023)));
    write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(m));
    repeat (30) begin
      send_item(OP_LOCATE, ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                pick_query(m), PARAM_W'($urandom_range(0, PARAM_MAX)), rand_cant(),
                PREDICTED, NO_LOC);
    end

    in_valid_i <= 1'b0;
    while (expected_locs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("arc_length_table_locate_core test passed");
    end else begin
      $display("arc_length_table_locate_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/altl_pkg.sv
rtl/core/altl_ram.sv
rtl/core/arc_length_table_locate_core.sv
tb/sv/arc_length_table_locate_core_tb.sv
